// File: rtl/core/olad_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// olad_pkg: shared definitions for the ordered list block
// Request codes, status codes, field widths and the default capacity.
// ----------------------------------------------------------------------------
package olad_pkg;

  localparam int unsigned DEFAULT_CAPACITY = 16;

  localparam int unsigned REQ_W    = 3;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 5;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_APPEND   = 3'd0;
  localparam logic [REQ_W-1:0] REQ_DEL_HEAD = 3'd1;
  localparam logic [REQ_W-1:0] REQ_DEL_KEY  = 3'd2;
  localparam logic [REQ_W-1:0] REQ_DEL_TAIL = 3'd3;
  localparam logic [REQ_W-1:0] REQ_LIST     = 3'd4;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

endpackage : olad_pkg
`default_nettype wire

// File: rtl/core/ordered_list_append_delete.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ordered_list_append_delete: packed ordered list with append and delete
// Holds up to CAPACITY signed 32-bit values head first in a memory with one
// write and one read port, walked by a small sequencer around one shared comparator.
// ----------------------------------------------------------------------------
// Usage
//   Request channel: a beat is taken at a rising edge with start high and
//   busy low; req_type and value are sampled there.
//   Result channel: each result beat sits on status, entry_value,
//   entry_count and last_result for exactly one cycle with result_valid
//   high. last_result marks the final beat of a request. The receiver
//   cannot stall, so every beat must be taken when shown.
//   Request handling (n = entries held when the request arrives):
//     append, delete tail, empty-list requests, unused codes: result in the
//       next cycle, busy never rises, one request per cycle.
//     delete head: each of the n-1 entries behind the head is read, then
//       written one slot down; the result shows as busy falls.
//     delete by key: each entry up to the match is read, then compared;
//       each entry behind it is read, then moved down to close the gap.
//     list: n beats in all, each entry read, then emitted as a beat.
//   Each busy step is one memory read, then a compare, a write back or a beat.
//   Reset clears the count and the sequencer; stored words stay undefined
//   until written and are never read before that.
// ----------------------------------------------------------------------------
module ordered_list_append_delete
  import olad_pkg::*;
#(
  parameter int unsigned CAPACITY = DEFAULT_CAPACITY
) (
  input  wire                        clk,
  input  wire                        rst,
  input  wire                        start,
  output logic                       busy,
  input  wire  [REQ_W-1:0]           req_type,
  input  wire  signed [DATA_W-1:0]   value,
  output logic                       result_valid,
  output logic [STATUS_W-1:0]        status,
  output logic signed [DATA_W-1:0]   entry_value,
  output logic [COUNT_W-1:0]         entry_count,
  output logic                       last_result
);

  localparam int unsigned PTR_W = $clog2(CAPACITY);
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  // Sequencer states, one-hot
  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_SR_RD  = 7'b0000010,  // read the entry under test
    S_SR_CMP = 7'b0000100,  // compare it with the key
    S_SH_RD  = 7'b0001000,  // read the entry above the gap
    S_SH_WR  = 7'b0010000,  // move it down into the gap
    S_LS_RD  = 7'b0100000,  // read the entry to list
    S_LS_OUT = 7'b1000000   // emit it as a result beat
  } state_t;

  state_t                   state, state_next;
  logic [CNT_W-1:0]         count, count_next;
  logic [PTR_W-1:0]         ptr, ptr_next;
  logic [DATA_W-1:0]        key, key_next;

  logic                     result_valid_next;
  logic [STATUS_W-1:0]      status_next;
  logic signed [DATA_W-1:0] entry_value_next;
  logic [COUNT_W-1:0]       entry_count_next;
  logic                     last_result_next;

  // Entry store and its ports
  logic [DATA_W-1:0]        mem [CAPACITY];
  logic                     mem_we;
  logic [PTR_W-1:0]         mem_waddr;
  logic [DATA_W-1:0]        mem_wdata;
  logic [PTR_W-1:0]         rd_addr;
  logic [DATA_W-1:0]        rd_data;

  logic                     accept;
  logic                     at_tail;
  logic                     shift_done;
  logic                     empty;
  logic                     full;

  assign busy       = (state != S_IDLE);
  assign accept     = start && !busy;
  assign empty      = (count == '0);
  assign full       = (count >= CNT_W'(CAPACITY));
  // true when ptr names the last held entry
  assign at_tail    = ((CNT_W'(ptr) + CNT_W'(1)) == count);
  // the gap has reached the slot below the tail
  assign shift_done = ((CNT_W'(ptr) + CNT_W'(2)) == count);

  // Read the entry above the gap while shifting, else the entry at ptr
  always_comb begin
    if (state == S_SH_RD) begin
      rd_addr = ptr + PTR_W'(1);
    end else begin
      rd_addr = ptr;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[rd_addr];
  end

  always_comb begin
    state_next        = state;
    count_next        = count;
    ptr_next          = ptr;
    key_next          = key;
    result_valid_next = 1'b0;
    status_next       = ST_OK;
    entry_value_next  = '0;
    last_result_next  = 1'b1;
    mem_we            = 1'b0;
    mem_waddr         = ptr;
    mem_wdata         = rd_data;

    case (state)
      S_IDLE: begin
        if (accept) begin
          case (req_type)
            REQ_APPEND: begin
              result_valid_next = 1'b1;
              if (full) begin
                status_next = ST_FULL;
              end else begin
                mem_we     = 1'b1;
                mem_waddr  = PTR_W'(count);
                mem_wdata  = value;
                count_next = count + CNT_W'(1);
              end
            end
            REQ_DEL_HEAD: begin
              if (empty) begin
                result_valid_next = 1'b1;
                status_next       = ST_EMPTY;
              end else if (count == CNT_W'(1)) begin
                result_valid_next = 1'b1;
                count_next        = '0;
              end else begin
                ptr_next   = '0;
                state_next = S_SH_RD;
              end
            end
            REQ_DEL_KEY: begin
              if (empty) begin
                result_valid_next = 1'b1;
                status_next       = ST_EMPTY;
              end else begin
                key_next   = value;
                ptr_next   = '0;
                state_next = S_SR_RD;
              end
            end
            REQ_DEL_TAIL: begin
              result_valid_next = 1'b1;
              if (empty) begin
                status_next = ST_EMPTY;
              end else begin
                count_next = count - CNT_W'(1);
              end
            end
            REQ_LIST: begin
              if (empty) begin
                result_valid_next = 1'b1;
                status_next       = ST_EMPTY;
              end else begin
                ptr_next   = '0;
                state_next = S_LS_RD;
              end
            end
            default: begin
              // unused codes: report ok, change nothing
              result_valid_next = 1'b1;
            end
          endcase
        end
      end
      S_SR_RD: begin
        state_next = S_SR_CMP;
      end
      S_SR_CMP: begin
        if (rd_data == key) begin
          if (at_tail) begin
            result_valid_next = 1'b1;
            count_next        = count - CNT_W'(1);
            state_next        = S_IDLE;
          end else begin
            state_next = S_SH_RD;
          end
        end else if (at_tail) begin
          result_valid_next = 1'b1;
          status_next       = ST_NOT_FOUND;
          state_next        = S_IDLE;
        end else begin
          ptr_next   = ptr + PTR_W'(1);
          state_next = S_SR_RD;
        end
      end
      S_SH_RD: begin
        state_next = S_SH_WR;
      end
      S_SH_WR: begin
        mem_we    = 1'b1;
        mem_waddr = ptr;
        mem_wdata = rd_data;
        if (shift_done) begin
          result_valid_next = 1'b1;
          count_next        = count - CNT_W'(1);
          state_next        = S_IDLE;
        end else begin
          ptr_next   = ptr + PTR_W'(1);
          state_next = S_SH_RD;
        end
      end
      S_LS_RD: begin
        state_next = S_LS_OUT;
      end
      S_LS_OUT: begin
        result_valid_next = 1'b1;
        entry_value_next  = rd_data;
        last_result_next  = at_tail;
        if (at_tail) begin
          state_next = S_IDLE;
        end else begin
          ptr_next   = ptr + PTR_W'(1);
          state_next = S_LS_RD;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    // every beat reports the count held after the request
    entry_count_next = COUNT_W'(count_next);
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      count        <= '0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      count        <= count_next;
      result_valid <= result_valid_next;
    end
  end

  // Payload: no reset needed
  always_ff @(posedge clk) begin
    ptr         <= ptr_next;
    key         <= key_next;
    status      <= status_next;
    entry_value <= entry_value_next;
    entry_count <= entry_count_next;
    last_result <= last_result_next;
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_count_in_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("held count exceeds capacity");

  a_status_beat_no_value: assert property (@(posedge clk) disable iff (rst)
    result_valid && (status != ST_OK) |-> (entry_value == '0) && last_result)
    else $error("status beat carries a value or is not final");

  a_more_beats_follow: assert property (@(posedge clk) disable iff (rst)
    result_valid && !last_result |-> busy)
    else $error("non-final beat with the sequencer idle");

  a_append_one_cycle: assert property (@(posedge clk) disable iff (rst)
    accept && (req_type == REQ_APPEND) |=> result_valid && last_result && !busy)
    else $error("append did not complete in one cycle");

  a_busy_no_accept_beat: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> $past(result_valid_next))
    else $error("sequencer returned to idle without a final beat");

endmodule : ordered_list_append_delete
`default_nettype wire

// File: verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the ordered list block
// Drives append, delete, list and unused-code requests through the start/busy
// port, predicts every result beat from a shadow copy of the list and checks
// the beats field by field as the strobe shows them.
// ----------------------------------------------------------------------------
module tb_top
  import olad_pkg::*;
;

  localparam int unsigned CAP         = DEFAULT_CAPACITY;
  localparam int          ITEM_TARGET = 410;
  localparam int          CYCLE_LIMIT = 400000;
  localparam int          TAIL_CYCLES = 4 * CAP + 8;

  // Request codes the block leaves unused: each still answers one ok beat
  localparam logic [REQ_W-1:0] REQ_SPARE_5 = 3'd5;
  localparam logic [REQ_W-1:0] REQ_SPARE_6 = 3'd6;
  localparam logic [REQ_W-1:0] REQ_SPARE_7 = 3'd7;

  typedef struct {
    logic [REQ_W-1:0]         req;
    logic signed [DATA_W-1:0] val;
    int                       gap;   // idle cycles after this beat is taken
    bit                       hold;  // wait for every result before showing
  } req_item_t;

  typedef struct {
    logic [STATUS_W-1:0]      status;
    logic signed [DATA_W-1:0] entry_value;
    logic [COUNT_W-1:0]       entry_count;
    logic                     last_result;
  } beat_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     start = 1'b0;
  logic [REQ_W-1:0]         req_type = '0;
  logic signed [DATA_W-1:0] value = '0;
  logic                     busy;
  logic                     result_valid;
  logic [STATUS_W-1:0]      status;
  logic signed [DATA_W-1:0] entry_value;
  logic [COUNT_W-1:0]       entry_count;
  logic                     last_result;

  // Stimulus and scoreboard storage
  req_item_t req_queue[$];
  beat_t     due_beats[$];
  int        items_total = 0;
  int        items_taken = 0;
  int        useful_items = 0;
  int        errors = 0;
  int        cycle_count = 0;
  int        idle_left = 0;
  bit        took_beat = 1'b0;
  bit        no_gaps = 1'b0;

  // Shadow of the list: head in slot 0, tail in slot list_len-1
  logic signed [DATA_W-1:0] list_words [CAP];
  int                       list_len = 0;

  ordered_list_append_delete #(
    .CAPACITY(CAP)
  ) DUT (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .req_type    (req_type),
    .value       (value),
    .result_valid(result_valid),
    .status      (status),
    .entry_value (entry_value),
    .entry_count (entry_count),
    .last_result (last_result)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Watchdog: give up well beyond the slowest legal run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[ordered_list_append_delete] ERROR");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // List predictor
  // --------------------------------------------------------------------------
  function automatic void push_beat(input logic [STATUS_W-1:0] st,
                                    input logic signed [DATA_W-1:0] v,
                                    input logic last);
    beat_t b;
    b.status      = st;
    b.entry_value = v;
    b.entry_count = list_len[COUNT_W-1:0];
    b.last_result = last;
    due_beats.push_back(b);
  endfunction

  // Close up the gap left at slot pos and shorten the list
  function automatic void close_gap(input int pos);
    for (int i = pos; i + 1 < list_len; i++) list_words[i] = list_words[i + 1];
    list_len--;
  endfunction

  // Update the shadow list for one accepted request and queue its beats
  function automatic void apply_request(input logic [REQ_W-1:0] req,
                                        input logic signed [DATA_W-1:0] val);
    logic [STATUS_W-1:0] st;
    int                  hit;
    st = ST_OK;
    case (req)
      REQ_APPEND: begin
        if (list_len >= CAP) begin
          st = ST_FULL;
        end else begin
          list_words[list_len] = val;
          list_len++;
        end
      end
      REQ_DEL_HEAD: begin
        if (list_len == 0) st = ST_EMPTY;
        else close_gap(0);
      end
      REQ_DEL_KEY: begin
        if (list_len == 0) begin
          st = ST_EMPTY;
        end else begin
          hit = -1;
          for (int i = 0; i < list_len; i++) begin
            if (hit < 0 && list_words[i] == val) hit = i;
          end
          if (hit < 0) st = ST_NOT_FOUND;
          else close_gap(hit);
        end
      end
      REQ_DEL_TAIL: begin
        if (list_len == 0) st = ST_EMPTY;
        else list_len--;
      end
      REQ_LIST: begin
        // A walk over the whole list: one beat per entry, the tail marked
        if (list_len == 0) begin
          push_beat(ST_EMPTY, '0, 1'b1);
        end else begin
          for (int i = 0; i < list_len; i++)
            push_beat(ST_OK, list_words[i], (i + 1 == list_len));
        end
        return;
      end
      default: ;  // spare codes: nothing changes
    endcase
    push_beat(st, '0, 1'b1);
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  // Mostly a small pool so that key deletes hit; the rest spans the full word
  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2:       return 32'sh0000_0000;
      3:       return -32'sd1;
      4, 5, 6: return $urandom_range(1, 6);
      default: return $urandom;
    endcase
  endfunction

  // Gaps: mostly none or short, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void add_req(input logic [REQ_W-1:0] req,
                                  input logic signed [DATA_W-1:0] val,
                                  input bit hold);
    req_item_t it;
    it.req  = req;
    it.val  = val;
    it.gap  = pick_gap();
    it.hold = hold;
    req_queue.push_back(it);
    if (req <= REQ_LIST) useful_items++;
  endfunction

  function automatic logic [REQ_W-1:0] pick_delete();
    case ($urandom_range(0, 3))
      0:       return REQ_DEL_HEAD;
      1:       return REQ_DEL_TAIL;
      default: return REQ_DEL_KEY;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Driver: change inputs on the falling edge, one beat at a time
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    req_item_t cur;
    bit        show;
    // keep showing a beat that the block has not yet taken
    show = start && !took_beat;
    if (!rst) begin
      if (!show) begin
        if (idle_left > 0) begin
          idle_left--;
        end else if (req_queue.size() > 0 &&
                     !(req_queue[0].hold && (due_beats.size() != 0 || busy))) begin
          cur = req_queue.pop_front();
          req_type <= cur.req;
          value    <= cur.val;
          idle_left = cur.gap;
          show = 1'b1;
        end
      end
      start <= show;
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: sample on the rising edge, check results before taking requests
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    beat_t want;
    took_beat = !rst && start && !busy;
    if (!rst && result_valid) begin
      if (due_beats.size() == 0) begin
        $error("result beat with nothing expected: status %0d value %0d count %0d last %0b",
               status, entry_value, entry_count, last_result);
        errors++;
      end else begin
        want = due_beats.pop_front();
        if (status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status);
          errors++;
        end
        if (entry_value !== want.entry_value) begin
          $error("entry_value: expected %0d, got %0d", want.entry_value, entry_value);
          errors++;
        end
        if (entry_count !== want.entry_count) begin
          $error("entry_count: expected %0d, got %0d", want.entry_count, entry_count);
          errors++;
        end
        if (last_result !== want.last_result) begin
          $error("last_result: expected %0b, got %0b", want.last_result, last_result);
          errors++;
        end
      end
    end
    if (took_beat) begin
      apply_request(req_type, value);
      items_taken++;
    end
  end

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    int n;
    int r;
    // Directed: every request on an empty list, spare codes, extreme values,
    // a duplicate key, an absent key, a removal from the middle
    add_req(REQ_LIST, $urandom, 1'b0);
    add_req(REQ_DEL_HEAD, $urandom, 1'b0);
    add_req(REQ_DEL_KEY, 32'sd0, 1'b0);
    add_req(REQ_DEL_TAIL, $urandom, 1'b0);
    add_req(REQ_SPARE_5, $urandom, 1'b0);
    add_req(REQ_SPARE_7, $urandom, 1'b0);
    add_req(REQ_APPEND, 32'sh8000_0000, 1'b0);
    add_req(REQ_APPEND, 32'sh7fff_ffff, 1'b0);
    add_req(REQ_APPEND, 32'sh0000_0000, 1'b0);
    add_req(REQ_APPEND, -32'sd1, 1'b0);
    add_req(REQ_APPEND, 32'sh5555_5555, 1'b0);
    add_req(REQ_APPEND, 32'shaaaa_aaaa, 1'b0);
    add_req(REQ_APPEND, 32'sh7fff_ffff, 1'b0);
    add_req(REQ_LIST, $urandom, 1'b0);
    add_req(REQ_DEL_KEY, 32'sh7fff_ffff, 1'b0);
    add_req(REQ_DEL_KEY, 32'sd12345, 1'b0);
    add_req(REQ_DEL_KEY, 32'sh0000_0000, 1'b0);
    add_req(REQ_DEL_HEAD, $urandom, 1'b0);
    add_req(REQ_DEL_TAIL, $urandom, 1'b0);
    add_req(REQ_SPARE_6, $urandom, 1'b0);
    add_req(REQ_LIST, $urandom, 1'b0);

    // Random: fill bursts that run past full, delete bursts and mixed
    // traffic; the first random beat waits for a quiet block
    add_req(REQ_APPEND, pick_value(), 1'b1);
    while (useful_items < ITEM_TARGET) begin
      no_gaps = ($urandom_range(0, 4) == 0);
      case ($urandom_range(0, 9))
        0, 1: begin
          n = $urandom_range(CAP + 1, CAP + 3);
          repeat (n) add_req(REQ_APPEND, pick_value(), 1'b0);
          add_req(REQ_LIST, $urandom, 1'b0);
        end
        2, 3: begin
          n = $urandom_range(4, CAP + 2);
          repeat (n) add_req(pick_delete(), pick_value(), 1'b0);
        end
        default: begin
          n = $urandom_range(1, 8);
          repeat (n) begin
            r = $urandom_range(0, 99);
            if (r < 38)      add_req(REQ_APPEND, pick_value(), $urandom_range(0, 49) == 0);
            else if (r < 48) add_req(REQ_DEL_HEAD, $urandom, 1'b0);
            else if (r < 70) add_req(REQ_DEL_KEY, pick_value(), 1'b0);
            else if (r < 80) add_req(REQ_DEL_TAIL, $urandom, 1'b0);
            else if (r < 96) add_req(REQ_LIST, $urandom, 1'b0);
            else             add_req(REQ_W'($urandom_range(REQ_SPARE_5, REQ_SPARE_7)),
                                     $urandom, 1'b0);
          end
        end
      endcase
    end
    items_total = req_queue.size();

    // Hold reset, then release it on a falling edge
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Wait for every beat to be taken and every result to arrive,
    // then let the block run on to catch any stray beat
    while (items_taken != items_total || due_beats.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (errors == 0 && due_beats.size() == 0) begin
      $display("[ordered_list_append_delete] OK");
    end else begin
      $display("[ordered_list_append_delete] ERROR");
    end
    $finish;
  end

endmodule : tb_top

// File: sim.f
rtl/core/olad_pkg.sv
rtl/core/ordered_list_append_delete.sv
verif/tb_top.sv
